>>> rtl/pal_pkg.sv
// Shared types and codes for the positional array list.
`default_nettype none

package pal_pkg;

    localparam int DATA_W  = 32;
    localparam int CMD_W   = 3;
    localparam int POS_W   = 5;
    localparam int STS_W   = 2;
    localparam int CNT_W   = 5;
    localparam int TDATA_W = 40;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

    localparam logic [STS_W-1:0] STS_OK      = 2'd0;
    localparam logic [STS_W-1:0] STS_BAD_POS = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL    = 2'd2;

    typedef struct packed {
        logic [STS_W-1:0]         status;
        logic signed [DATA_W-1:0] data;
        logic                     found;
        logic [CNT_W-1:0]         count;
    } pal_result_t;

endpackage

`default_nettype wire

>>> rtl/pal_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> rtl/pal_ctrl.sv
// Command sequencer: decodes a command and walks the entry RAM one address per cycle.
`default_nettype none

module pal_ctrl #(
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [pal_pkg::CMD_W-1:0]           in_cmd,
    input  wire logic signed [pal_pkg::DATA_W-1:0]   in_value,
    input  wire logic [pal_pkg::POS_W-1:0]           in_position,
    input  wire logic                                slot_free,
    output logic                                     res_valid,
    output pal_pkg::pal_result_t                     res,
    output logic                                     mem_we,
    output logic [AW-1:0]                            mem_waddr,
    output logic [pal_pkg::DATA_W-1:0]               mem_wdata,
    output logic [AW-1:0]                            mem_raddr,
    input  wire logic [pal_pkg::DATA_W-1:0]          mem_rdata
);

    import pal_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SHIFT_UP = 7'b0000010,
        S_INS_WR   = 7'b0000100,
        S_SHIFT_DN = 7'b0001000,
        S_GET_RD   = 7'b0010000,
        S_FIND     = 7'b0100000,
        S_RESP     = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [CW-1:0]       fill_reg, fill_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [STS_W-1:0]    status_reg, status_next;
    logic [DATA_W-1:0]   data_reg, data_next;
    logic                found_reg, found_next;

    logic [PW-1:0]       pos_ext;
    logic [PW-1:0]       fill_ext;
    logic                is_full;
    logic [AW-1:0]       fill_last;
    logic [AW-1:0]       idx_dec;
    logic [AW-1:0]       idx_inc;

    assign pos_ext   = PW'(in_position);
    assign fill_ext  = PW'(fill_reg);
    assign is_full   = (fill_reg == CW'(DEPTH));
    assign fill_last = AW'(fill_reg - CW'(1));
    assign idx_dec   = idx_reg - AW'(1);
    assign idx_inc   = idx_reg + AW'(1);

    assign in_ready   = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_RESP);
    assign res.status = status_reg;
    assign res.data   = data_reg;
    assign res.found  = found_reg;
    assign res.count  = CNT_W'(fill_reg);

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        status_next = status_reg;
        data_next   = data_reg;
        found_next  = found_reg;
        mem_we      = 1'b0;
        mem_waddr   = pos_reg;
        mem_wdata   = val_reg;
        mem_raddr   = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pos_next    = AW'(in_position);
                    val_next    = in_value;
                    status_next = STS_OK;
                    data_next   = '0;
                    found_next  = 1'b0;
                    state_next  = S_RESP;
                    unique case (in_cmd)
                        CMD_INSERT:
                        begin
                            if (pos_ext > fill_ext)
                            begin
                                status_next = STS_BAD_POS;
                            end
                            else if (is_full)
                            begin
                                status_next = STS_FULL;
                            end
                            else if (pos_ext == fill_ext)
                            begin
                                // append: no entries to move
                                mem_we    = 1'b1;
                                mem_waddr = AW'(in_position);
                                mem_wdata = in_value;
                                fill_next = fill_reg + CW'(1);
                            end
                            else
                            begin
                                mem_raddr  = fill_last;
                                idx_next   = fill_last;
                                state_next = S_SHIFT_UP;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (pos_ext >= fill_ext)
                            begin
                                status_next = STS_BAD_POS;
                            end
                            else if (AW'(in_position) == fill_last)
                            begin
                                fill_next = fill_reg - CW'(1);
                            end
                            else
                            begin
                                mem_raddr  = AW'(in_position) + AW'(1);
                                idx_next   = AW'(in_position) + AW'(1);
                                state_next = S_SHIFT_DN;
                            end
                        end
                        CMD_GET:
                        begin
                            if (pos_ext >= fill_ext)
                            begin
                                status_next = STS_BAD_POS;
                            end
                            else
                            begin
                                mem_raddr  = AW'(in_position);
                                state_next = S_GET_RD;
                            end
                        end
                        CMD_UPDATE:
                        begin
                            if (pos_ext >= fill_ext)
                            begin
                                status_next = STS_BAD_POS;
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(in_position);
                                mem_wdata = in_value;
                            end
                        end
                        CMD_FIND:
                        begin
                            if (fill_reg != '0)
                            begin
                                mem_raddr  = '0;
                                idx_next   = '0;
                                state_next = S_FIND;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SHIFT_UP:
            begin
                // move the entry read last cycle one place up
                mem_we    = 1'b1;
                mem_waddr = idx_inc;
                mem_wdata = mem_rdata;
                if (idx_reg == pos_reg)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    mem_raddr = idx_dec;
                    idx_next  = idx_dec;
                end
            end
            S_INS_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = val_reg;
                fill_next  = fill_reg + CW'(1);
                state_next = S_RESP;
            end
            S_SHIFT_DN:
            begin
                // move the entry read last cycle one place down
                mem_we    = 1'b1;
                mem_waddr = idx_dec;
                mem_wdata = mem_rdata;
                if (idx_reg == fill_last)
                begin
                    fill_next  = fill_reg - CW'(1);
                    state_next = S_RESP;
                end
                else
                begin
                    mem_raddr = idx_inc;
                    idx_next  = idx_inc;
                end
            end
            S_GET_RD:
            begin
                data_next  = mem_rdata;
                state_next = S_RESP;
            end
            S_FIND:
            begin
                if (mem_rdata == val_reg)
                begin
                    found_next = 1'b1;
                end
                if (idx_reg == fill_last)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    mem_raddr = idx_inc;
                    idx_next  = idx_inc;
                end
            end
            S_RESP:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        found_reg  <= found_next;
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill count above depth");

    a_shift_up_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT_UP) |-> (idx_reg >= pos_reg))
        else $error("insert walk passed its stop index");

    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP) && !slot_free |=> (state_reg == S_RESP))
        else $error("result dropped while output slot busy");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> (state_reg != S_IDLE))
        else $error("accepted command produced no work");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIND) || (state_reg == S_SHIFT_DN) |-> (idx_reg <= fill_last))
        else $error("walk beyond stored entries");

endmodule

`default_nettype wire

>>> rtl/positional_array_list.sv
// Sequence: append, update, clear, invalid or full cases go from idle straight to the result
// state; get first reads the entry. A middle insert shifts entries up, last one first, down to
// position, then writes the value. Remove walks the entries above position; find walks all of them.
// Throughput: one command at a time; s_tready returns the cycle after the result is latched,
// since every walk goes through the single read and write port of the entry RAM.
// Reset: asynchronous, active low; clears the list length, entry RAM contents are left as is.
`default_nettype none

module positional_array_list #(
    parameter int DEPTH = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // command [2:0], value [34:3], position [39:35]
    input  wire logic [pal_pkg::TDATA_W-1:0]   s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // status [1:0], data [33:2], found [34], count [39:35]
    output logic [pal_pkg::TDATA_W-1:0]        m_tdata
);

    import pal_pkg::*;

    localparam int AW = $clog2(DEPTH);

    // Unpack the incoming beat.
    logic [CMD_W-1:0]         in_cmd;
    logic signed [DATA_W-1:0] in_value;
    logic [POS_W-1:0]         in_position;

    assign in_cmd      = s_tdata[2:0];
    assign in_value    = s_tdata[34:3];
    assign in_position = s_tdata[39:35];

    // Output register: a finished result sits here until the sink takes the beat,
    // so the sequencer can go back to idle as soon as the slot is free.
    logic                m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic                slot_free;
    logic                res_valid;
    pal_result_t         res;

    // Entry RAM connections.
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [DATA_W-1:0]   mem_wdata;
    logic [AW-1:0]       mem_raddr;
    logic [DATA_W-1:0]   mem_rdata;

    assign slot_free = !m_tvalid_reg || m_tready;

    pal_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pal_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_cmd      (in_cmd),
        .in_value    (in_value),
        .in_position (in_position),
        .slot_free   (slot_free),
        .res_valid   (res_valid),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    // Load a new beat when the sequencer hands one over, drop valid once taken.
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid && slot_free)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {res.count, res.found, res.data, res.status};
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
